FILE: hdl/mtep_pkg.sv
// Shared types and constants for the MIDI track event parser.
// Holds the per-clip context layout, the result layout and the status codes.
// No dependencies.
`default_nettype none

package mtep_pkg;

  localparam int NUM_CLIPS_DEF = 8;
  localparam int CLIP_W        = 3;
  localparam int ACC_W         = 28;
  localparam int TICK_W        = 32;

  // Status bytes with special handling
  localparam logic [7:0] ST_SYSEX   = 8'hF0;
  localparam logic [7:0] ST_ESCAPE  = 8'hF7;
  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] RS_DEFAULT = 8'h80;
  localparam logic [3:0] PKT_SYS    = 4'hF;

  typedef enum logic [3:0] {
    PH_DELTA    = 4'd0,
    PH_EVENT    = 4'd1,
    PH_DATA1    = 4'd2,
    PH_DATA2    = 4'd3,
    PH_SXLEN    = 4'd4,
    PH_SXDATA   = 4'd5,
    PH_METATYPE = 4'd6,
    PH_METALEN  = 4'd7,
    PH_METASKIP = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    LEN_NONE  = 2'd0,
    LEN_TWO   = 2'd2,
    LEN_THREE = 2'd3
  } evlen_t;

  // One clip's parse context, as stored in the context memory
  typedef struct packed {
    phase_t              phase;
    logic [7:0]          running;
    logic [TICK_W-1:0]   tick;
    logic [ACC_W-1:0]    length_accum;
    logic [ACC_W-1:0]    bytes_left;
    logic [7:0]          status_hold;
    logic [7:0]          data_hold;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    phase:        PH_DELTA,
    running:      RS_DEFAULT,
    tick:         '0,
    length_accum: '0,
    bytes_left:   '0,
    status_hold:  '0,
    data_hold:    '0
  };

  // One emitted event
  typedef struct packed {
    logic [CLIP_W-1:0]   clip;
    logic [3:0]          pkt_type;
    logic [7:0]          status;
    logic [7:0]          data_one;
    logic [7:0]          data_two;
    logic [TICK_W-1:0]   tick;
  } res_t;

  // Number of bytes in a voice event, from its status byte
  function automatic evlen_t event_len(input logic [7:0] st);
    evlen_t n;
    case (st[7:4]) inside
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = LEN_THREE;
      4'hC, 4'hD:                   n = LEN_TWO;
      default:                      n = LEN_NONE;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mtep_ctx_mem.sv
// Per-clip context memory with registered read, valid bits and write forwarding.
// Depends on mtep_pkg for ctx_t and the reset context.
`default_nettype none

module mtep_ctx_mem
  import mtep_pkg::*;
#(
  parameter int NUM_CLIPS = NUM_CLIPS_DEF,
  parameter int AW        = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_idx,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_idx,
  input  wire ctx_t          wr_ctx,
  output ctx_t               rd_ctx
);

  ctx_t                 mem [NUM_CLIPS];
  logic [NUM_CLIPS-1:0] valid;
  ctx_t                 rd_data;
  logic                 rd_vld;
  logic                 fwd_hit;
  ctx_t                 fwd_ctx;

  // Write back the updated context
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ctx;
    end
  end

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Read the entry and note a write to it in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
      fwd_ctx <= wr_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      rd_vld  <= valid[rd_idx];
      fwd_hit <= wr_en && (wr_idx == rd_idx);
    end
  end

  // Forward the colliding write, else fall back to the reset context
  assign rd_ctx = fwd_hit ? fwd_ctx : (rd_vld ? rd_data : CTX_RESET);

  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(wr_idx)])
    else $error("written context not marked valid");

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (rst)
    (rd_en && !wr_en) |=> !fwd_hit)
    else $error("forwarding without a colliding write");

  a_fwd_data: assert property (@(posedge clk) disable iff (rst)
    (rd_en && wr_en && wr_idx == rd_idx) |=> (rd_ctx == $past(wr_ctx)))
    else $error("colliding write not forwarded");

endmodule

`default_nettype wire

FILE: hdl/mtep_step.sv
// Byte parser: next context and optional event for one byte of one clip.
// Depends on mtep_pkg for the context, result and status codes.
`default_nettype none

module mtep_step
  import mtep_pkg::*;
(
  input  wire ctx_t              ctx,
  input  wire logic [CLIP_W-1:0] clip,
  input  wire logic [7:0]        data_byte,
  input  wire logic              track_start,
  output ctx_t                   ctx_next,
  output logic                   emit,
  output res_t                   res
);

  always_comb begin
    ctx_t             base;
    logic [ACC_W-1:0] acc_n;
    logic [ACC_W-1:0] left_n;
    logic [7:0]       st;
    logic             take1;

    base  = track_start ? CTX_RESET : ctx;
    acc_n = {base.length_accum[ACC_W-8:0], data_byte[6:0]};
    left_n = base.bytes_left - ACC_W'(1);
    st    = base.status_hold;
    take1 = 1'b0;

    ctx_next     = base;
    emit         = 1'b0;
    res.clip     = clip;
    res.pkt_type = PKT_SYS;
    res.status   = data_byte;
    res.data_one = '0;
    res.data_two = '0;
    res.tick     = base.tick;

    case (base.phase)
      PH_DELTA: begin
        ctx_next.length_accum = acc_n;
        // Close the delta on a byte without continuation bit
        if (!data_byte[7]) begin
          ctx_next.tick         = base.tick + {{(TICK_W-ACC_W){1'b0}}, acc_n};
          ctx_next.length_accum = '0;
          ctx_next.phase        = PH_EVENT;
        end
      end
      PH_EVENT: begin
        ctx_next.length_accum = '0;
        if (data_byte == ST_SYSEX) begin
          ctx_next.phase = PH_SXLEN;
          emit           = 1'b1;
        end else if (data_byte == ST_ESCAPE) begin
          ctx_next.phase = PH_SXLEN;
        end else if (data_byte == ST_META) begin
          ctx_next.phase = PH_METATYPE;
        end else if (data_byte[7]) begin
          ctx_next.running     = data_byte;
          ctx_next.status_hold = data_byte;
          ctx_next.phase       = PH_DATA1;
        end else begin
          // Running status: this byte is the first data byte
          st                   = base.running;
          ctx_next.status_hold = base.running;
          take1                = 1'b1;
        end
      end
      PH_DATA1: begin
        take1 = 1'b1;
      end
      PH_DATA2: begin
        ctx_next.phase = PH_DELTA;
        emit           = 1'b1;
        res.pkt_type   = st[7:4];
        res.status     = st;
        res.data_one   = base.data_hold;
        res.data_two   = data_byte;
      end
      PH_SXLEN, PH_METALEN: begin
        ctx_next.length_accum = acc_n;
        if (!data_byte[7]) begin
          ctx_next.bytes_left   = acc_n;
          ctx_next.length_accum = '0;
          if (acc_n == '0) begin
            ctx_next.phase = PH_DELTA;
          end else if (base.phase == PH_SXLEN) begin
            ctx_next.phase = PH_SXDATA;
          end else begin
            ctx_next.phase = PH_METASKIP;
          end
        end
      end
      PH_SXDATA: begin
        ctx_next.bytes_left = left_n;
        if (left_n == '0) begin
          ctx_next.phase = PH_DELTA;
        end
        emit = 1'b1;
      end
      PH_METATYPE: begin
        ctx_next.length_accum = '0;
        ctx_next.phase        = PH_METALEN;
      end
      PH_METASKIP: begin
        ctx_next.bytes_left = left_n;
        if (left_n == '0) begin
          ctx_next.phase = PH_DELTA;
        end
      end
      default: begin
        ctx_next.phase = PH_DELTA;
      end
    endcase

    // First data byte of a voice event
    if (take1) begin
      case (event_len(st))
        LEN_THREE: begin
          ctx_next.data_hold = data_byte;
          ctx_next.phase     = PH_DATA2;
        end
        LEN_TWO: begin
          ctx_next.phase = PH_DELTA;
          emit           = 1'b1;
          res.pkt_type   = st[7:4];
          res.status     = st;
          res.data_one   = data_byte;
        end
        default: begin
          ctx_next.phase = PH_DELTA;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mtep_out_buf.sv
// Two-entry output buffer that decouples the parser from the receiver.
// Depends on mtep_pkg for res_t.
`default_nettype none

module mtep_out_buf
  import mtep_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t push_res,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_res
);

  res_t       head;
  res_t       tail;
  logic [1:0] count;
  logic       pop;

  assign pop       = (count != 2'd0) && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_res   = head;

  // Move items through head and tail
  always_ff @(posedge clk) begin
    if (pop && !push) begin
      head <= tail;
    end else if (push && !pop) begin
      if (count == 2'd0) begin
        head <= push_res;
      end else begin
        tail <= push_res;
      end
    end else if (push && pop) begin
      if (count == 2'd1) begin
        head <= push_res;
      end else begin
        head <= tail;
        tail <= push_res;
      end
    end
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full output buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("output buffer count out of range");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && out_res == $past(out_res)))
    else $error("stalled head item changed");

endmodule

`default_nettype wire

FILE: hdl/midi_track_event_parser_core.sv
// MIDI track event parser: byte stream in, voice and SysEx events out.
// Usage:
//   Slave channel: one track byte per item in s_tdata, with the clip number
//   and a track-start flag in s_tuser. Each clip has its own parse context
//   (delta accumulator, absolute tick, running status, length counters).
//   Master channel: one decoded event per item; bytes that complete no event
//   produce nothing. Bytes tagged with a clip number at or above NUM_CLIPS
//   are dropped.
// Throughput: one byte per cycle unless the parse stage stalls, also when
//   consecutive bytes hit the same clip; that rate comes from the context
//   read-modify-write, with the write forwarded to a read of the same clip.
// Output path: the byte and its context read are registered into the parse
//   stage, and each event is registered in the output buffer before output.
// Reset: rst clears all contexts at once through per-clip valid bits; the
//   block accepts bytes as soon as reset is released.
// Stall: a two-entry output buffer holds events; while it is full and the
//   byte being parsed completes an event, s_tready drops until the receiver
//   takes an item. Bytes that emit nothing keep flowing.
`default_nettype none

module midi_track_event_parser_core
  import mtep_pkg::*;
#(
  parameter int NUM_CLIPS = NUM_CLIPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [3:0]  s_tuser,   // [2:0] clip_id, [3] track_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [7:0] status_byte, [15:8] data_one,
                                      // [23:16] data_two, [55:24] event_tick
  output logic [6:0]       m_tuser    // [2:0] clip_out, [6:3] pkt_type
);

  localparam int AW = (NUM_CLIPS > 1) ? $clog2(NUM_CLIPS) : 1;

  logic              accept;
  logic              s1_valid;
  logic [CLIP_W-1:0] s1_clip;
  logic [7:0]        s1_byte;
  logic              s1_start;
  logic              s1_in_range;
  logic              s1_go;
  logic [6:0]        in_clip_ext;
  logic [6:0]        s1_clip_ext;
  ctx_t              rd_ctx;
  ctx_t              ctx_next;
  logic              step_emit;
  logic              push;
  logic              buf_full;
  res_t              step_res;
  res_t              out_res;

  assign in_clip_ext = {4'b0, s_tuser[CLIP_W-1:0]};
  assign s1_clip_ext = {4'b0, s1_clip};
  assign s1_in_range = (s1_clip_ext < 7'(NUM_CLIPS));

  // Hold the parse stage only when its event finds the buffer full
  assign push     = s1_valid && s1_in_range && step_emit;
  assign s1_go    = !push || !buf_full;
  assign s_tready = !s1_valid || s1_go;
  assign accept   = s_tvalid && s_tready;

  // Advance the byte into the parse stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_clip  <= s_tuser[CLIP_W-1:0];
      s1_byte  <= s_tdata;
      s1_start <= s_tuser[CLIP_W];
    end
  end

  mtep_ctx_mem #(
    .NUM_CLIPS (NUM_CLIPS),
    .AW        (AW)
  ) u_ctx_mem (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_idx (in_clip_ext[AW-1:0]),
    .wr_en  (s1_valid && s1_go && s1_in_range),
    .wr_idx (s1_clip_ext[AW-1:0]),
    .wr_ctx (ctx_next),
    .rd_ctx (rd_ctx)
  );

  mtep_step u_step (
    .ctx         (rd_ctx),
    .clip        (s1_clip),
    .data_byte   (s1_byte),
    .track_start (s1_start),
    .ctx_next    (ctx_next),
    .emit        (step_emit),
    .res         (step_res)
  );

  mtep_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push && s1_go),
    .push_res  (step_res),
    .full      (buf_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {out_res.tick, out_res.data_two, out_res.data_one, out_res.status};
  assign m_tuser = {out_res.pkt_type, out_res.clip};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> !s_tready)
    else $error("input taken while parse stage is stalled");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_byte) && $stable(s1_clip)))
    else $error("stalled byte lost");

  a_drop_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_in_range) |-> !push)
    else $error("event from out-of-range clip");

endmodule

`default_nettype wire
